[sv/dfs_pkg.sv]
// Shared types and constants for the delimited field splitter.
package dfs_pkg;

   // Field and register widths
   localparam int BYTE_W    = 8;
   localparam int PAT_W     = 32;
   localparam int LEN_W     = 3;
   localparam int PAT_BYTES = PAT_W / BYTE_W;
   localparam int CSR_IDX_W = 2;

   // Default window size in bytes
   localparam int MAX_PATTERN_DEFAULT = 4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DELIM_PAT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELIM_LEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENCL_PAT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ENCL_LEN  = 2'd3;

   // Register reset values: comma, one byte, double quote, one byte
   localparam logic [PAT_W-1:0] DELIM_PAT_RESET = 32'd44;
   localparam logic [LEN_W-1:0] DELIM_LEN_RESET = 3'd1;
   localparam logic [PAT_W-1:0] ENCL_PAT_RESET  = 32'd34;
   localparam logic [LEN_W-1:0] ENCL_LEN_RESET  = 3'd1;

   // Pattern configuration seen by the scanner
   typedef struct packed {
      logic [PAT_W-1:0] delim_pat;
      logic [LEN_W-1:0] delim_len;
      logic [PAT_W-1:0] encl_pat;
      logic [LEN_W-1:0] encl_len;
   } cfg_type;

   // One result item
   typedef struct packed {
      logic [BYTE_W-1:0] field_byte;
      logic              is_byte;
      logic              last_field;
      logic              unbalanced;
   } rsp_type;

endpackage

[sv/dfs_csr.sv]
// Pattern configuration registers of the delimited field splitter.
module dfs_csr
   import dfs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PAT_W-1:0]     csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_DELIM_PAT: cfg_in.delim_pat = csr_wdata;
            CSR_DELIM_LEN: cfg_in.delim_len = csr_wdata[LEN_W-1:0];
            CSR_ENCL_PAT:  cfg_in.encl_pat  = csr_wdata;
            CSR_ENCL_LEN:  cfg_in.encl_len  = csr_wdata[LEN_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delim_pat <= DELIM_PAT_RESET;
         cfg_ff.delim_len <= DELIM_LEN_RESET;
         cfg_ff.encl_pat  <= ENCL_PAT_RESET;
         cfg_ff.encl_len  <= ENCL_LEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[sv/dfs_scan.sv]
// Lookahead window, quote tracking and per-item result generation.
module dfs_scan
   import dfs_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT,
   localparam int PAT_CAP   = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES,
   localparam int RES_DEPTH = PAT_CAP + 1,
   localparam int RES_CNT_W = $clog2(RES_DEPTH + 1)
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [BYTE_W-1:0]    in_byte,
   input  logic                 in_present,
   input  logic                 in_line_end,
   input  cfg_type              cfg,
   output rsp_type              res [RES_DEPTH],
   output logic [RES_CNT_W-1:0] res_count
);

   localparam int CNT_W     = $clog2(PAT_CAP + 1);
   localparam int EXT_DEPTH = 2 * PAT_CAP;
   localparam int EXT_IW    = $clog2(EXT_DEPTH);
   localparam int RES_IW    = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;

   // Window state
   logic [BYTE_W-1:0] la_bytes_ff [PAT_CAP];
   logic [BYTE_W-1:0] la_bytes_in [PAT_CAP];
   logic [CNT_W-1:0]  la_count_ff, la_count_in;
   logic [CNT_W-1:0]  skip_ff, skip_in;
   logic              inside_ff, inside_in;

   // Window with the new byte appended; the upper half pads matches
   logic [BYTE_W-1:0] ext [EXT_DEPTH];

   function automatic rsp_type make_rsp(input logic [BYTE_W-1:0] b, input logic isb,
                                        input logic last, input logic unb);
      rsp_type r;
      r.field_byte = b;
      r.is_byte    = isb;
      r.last_field = last;
      r.unbalanced = unb;
      return r;
   endfunction

   // Decide every position that the item completes
   always_comb begin : scan_logic
      logic [LEN_W-1:0]     dl;
      logic [LEN_W-1:0]     el;
      logic [LEN_W-1:0]     need;
      logic [CNT_W-1:0]     cnt_new;
      logic [CNT_W-1:0]     n_iter;
      logic [CNT_W-1:0]     rem;
      logic [CNT_W-1:0]     skip_v;
      logic                 inside_v;
      logic                 enc_hit;
      logic                 del_hit;
      logic [RES_CNT_W-1:0] idx;
      logic [EXT_IW-1:0]    src;

      // Clamp lengths; delimiter is at least one byte
      if (cfg.delim_len == '0)
         dl = LEN_W'(1);
      else if (cfg.delim_len > LEN_W'(PAT_CAP))
         dl = LEN_W'(PAT_CAP);
      else
         dl = cfg.delim_len;
      el   = (cfg.encl_len > LEN_W'(PAT_CAP)) ? LEN_W'(PAT_CAP) : cfg.encl_len;
      need = (dl > el) ? dl : el;

      for (int j = 0; j < EXT_DEPTH; j++) begin
         ext[j] = '0;
      end
      for (int j = 0; j < PAT_CAP; j++) begin
         ext[j] = (CNT_W'(j) == la_count_ff) ? in_byte : la_bytes_ff[j];
      end

      cnt_new = la_count_ff + CNT_W'(in_present);

      // Number of positions decided by this item
      if (!in_present && !in_line_end)
         n_iter = '0;
      else if (in_line_end)
         n_iter = cnt_new;
      else if (cnt_new >= CNT_W'(need))
         n_iter = cnt_new - CNT_W'(need) + CNT_W'(1);
      else
         n_iter = '0;

      skip_v   = skip_ff;
      inside_v = inside_ff;
      idx      = '0;
      for (int j = 0; j < RES_DEPTH; j++) begin
         res[j] = '0;
      end

      for (int i = 0; i < PAT_CAP; i++) begin
         rem = cnt_new - CNT_W'(i);

         // Pattern compares at this position, wholly within the line
         enc_hit = (el != '0) && (CNT_W'(el) <= rem);
         del_hit = (CNT_W'(dl) <= rem);
         for (int k = 0; k < PAT_CAP; k++) begin
            if (LEN_W'(k) < el && ext[i+k] != cfg.encl_pat[BYTE_W*k +: BYTE_W])
               enc_hit = 1'b0;
            if (LEN_W'(k) < dl && ext[i+k] != cfg.delim_pat[BYTE_W*k +: BYTE_W])
               del_hit = 1'b0;
         end

         if (CNT_W'(i) < n_iter) begin
            if (skip_v != '0) begin
               skip_v = skip_v - CNT_W'(1);
            end else begin
               if (enc_hit)
                  inside_v = ~inside_v;
               if (!inside_v && del_hit) begin
                  res[idx[RES_IW-1:0]] = make_rsp('0, 1'b0, 1'b0, 1'b0);
                  skip_v = CNT_W'(dl - LEN_W'(1));
               end else begin
                  res[idx[RES_IW-1:0]] = make_rsp(ext[i], 1'b1, 1'b0, 1'b0);
               end
               idx = idx + RES_CNT_W'(1);
            end
         end
      end

      // Closing field end of the line
      if (in_line_end) begin
         res[idx[RES_IW-1:0]] = make_rsp('0, 1'b0, 1'b1, inside_v);
         idx = idx + RES_CNT_W'(1);
      end
      res_count = idx;

      // Shift out decided bytes
      for (int j = 0; j < PAT_CAP; j++) begin
         src = EXT_IW'(n_iter) + EXT_IW'(j);
         la_bytes_in[j] = ext[src];
      end
      if (in_line_end) begin
         la_count_in = '0;
         skip_in     = '0;
         inside_in   = 1'b0;
      end else begin
         la_count_in = cnt_new - n_iter;
         skip_in     = skip_v;
         inside_in   = inside_v;
      end
   end

   // State commit when the item moves to the result buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         la_count_ff <= '0;
         skip_ff     <= '0;
         inside_ff   <= 1'b0;
      end else if (advance) begin
         la_count_ff <= la_count_in;
         skip_ff     <= skip_in;
         inside_ff   <= inside_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         la_bytes_ff <= la_bytes_in;
      end
   end

endmodule

[sv/dfs_rsp_buf.sv]
// Result buffer: holds the results of one item and drains one per cycle while rsp_ready is high.
module dfs_rsp_buf
   import dfs_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT,
   localparam int PAT_CAP   = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES,
   localparam int RES_DEPTH = PAT_CAP + 1,
   localparam int RES_CNT_W = $clog2(RES_DEPTH + 1)
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  rsp_type              load_data [RES_DEPTH],
   input  logic [RES_CNT_W-1:0] load_count,
   output logic                 can_load,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data
);

   localparam int RES_IW = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;

   rsp_type              buf_ff [RES_DEPTH];
   logic [RES_IW-1:0]    rd_ff, rd_in;
   logic [RES_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 take;

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = buf_ff[rd_ff];
   assign take      = rsp_valid && rsp_ready;
   // Free once the last held item leaves this cycle
   assign can_load  = (cnt_ff == '0) || ((cnt_ff == RES_CNT_W'(1)) && rsp_ready);

   // Read pointer and fill count
   always_comb begin
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (load) begin
         rd_in  = '0;
         cnt_in = load_count;
      end else if (take) begin
         rd_in  = RES_IW'(rd_ff + RES_IW'(1));
         cnt_in = cnt_ff - RES_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         buf_ff <= load_data;
      end
   end

endmodule

[sv/delimited_field_splitter.sv]
// Top level of the delimited field splitter (CSV-style field tokenizer).
//
// Usage: text lines enter on the req_ channel one byte per item; req_line_end
// closes a line, and req_byte_present low with req_line_end high closes a line
// with no new byte. The rsp_ channel returns field bytes (rsp_is_byte high)
// and field ends (rsp_is_byte low); the field end that closes a line has
// rsp_last_field high and rsp_unbalanced set if an enclosure is still open.
// Patterns are loaded through csr_wen / csr_index / csr_wdata while idle.
// Each item is held in an input register, decided combinationally and
// written to the result buffer when the buffer is free. Throughput: one
// item per cycle while each item yields at most one result and rsp_ready
// is high. An item yielding n results occupies the result buffer until all
// n have been taken; a line end can yield up to MAX_PATTERN+1 (capped at 5).
// When rsp_ready is low, results wait in the buffer and one more item is
// taken into the input register before req_ready drops.
// Reset restores the comma delimiter and double-quote enclosure, clears the
// lookahead window, the quote state and both buffers.
module delimited_field_splitter
   import dfs_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
)
(
   input  logic                 clock,
   input  logic                 reset,
   // Input channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [BYTE_W-1:0]    req_text_byte,
   input  logic                 req_byte_present,
   input  logic                 req_line_end,
   // Result channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [BYTE_W-1:0]    rsp_field_byte,
   output logic                 rsp_is_byte,
   output logic                 rsp_last_field,
   output logic                 rsp_unbalanced,
   // Configuration
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PAT_W-1:0]     csr_wdata
);

   localparam int PAT_CAP   = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;
   localparam int RES_DEPTH = PAT_CAP + 1;
   localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

   cfg_type              cfg;
   rsp_type              res [RES_DEPTH];
   logic [RES_CNT_W-1:0] res_count;
   rsp_type              rsp_data;
   logic                 can_load;
   logic                 advance;

   // Input register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_present_ff;
   logic              in_line_end_ff;
   logic              req_take;

   assign advance   = in_valid_ff && can_load;
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take)
         in_valid_in = 1'b1;
      else if (advance)
         in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff     <= req_text_byte;
         in_present_ff  <= req_byte_present;
         in_line_end_ff <= req_line_end;
      end
   end

   dfs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dfs_scan #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_byte     (in_byte_ff),
      .in_present  (in_present_ff),
      .in_line_end (in_line_end_ff),
      .cfg         (cfg),
      .res         (res),
      .res_count   (res_count)
   );

   dfs_rsp_buf #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .load_data  (res),
      .load_count (res_count),
      .can_load   (can_load),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_field_byte = rsp_data.field_byte;
   assign rsp_is_byte    = rsp_data.is_byte;
   assign rsp_last_field = rsp_data.last_field;
   assign rsp_unbalanced = rsp_data.unbalanced;

endmodule
